// File: rtl/inverse_4x4_transform_recon_top_defines.svh
// Assertion macros for the reconstruction block's top-level RTL file
`ifndef INVERSE_4X4_TRANSFORM_RECON_TOP_DEFINES_SVH
`define INVERSE_4X4_TRANSFORM_RECON_TOP_DEFINES_SVH

// Same-cycle implication, checked on clk, masked while reset is asserted
`define ITR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, masked while reset is asserted
`define ITR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/itr_pkg.sv
// Shared types and constants for the 4x4 inverse transform and reconstruction block
package itr_pkg;

  localparam int BLK_N       = 16;
  localparam int ADDR_W      = 4;
  localparam int COEF_W      = 24;
  localparam int PIX_W       = 8;
  localparam int ROW_W       = 30;
  localparam int BF_W        = 36;
  localparam int SCALE_SHIFT = 20;
  localparam int SUM_W       = ((BF_W > PIX_W + SCALE_SHIFT) ? BF_W : PIX_W + SCALE_SHIFT) + 2;
  localparam int SH_W        = SUM_W - SCALE_SHIFT;
  localparam int PIX_MAX     = 255;

  localparam logic signed [BF_W-1:0] K13 = BF_W'(13);
  localparam logic signed [BF_W-1:0] K7  = BF_W'(7);
  localparam logic signed [BF_W-1:0] K17 = BF_W'(17);

  localparam logic PASS_ROW = 1'b0;
  localparam logic PASS_COL = 1'b1;

  typedef struct packed {
    logic signed [COEF_W-1:0] coefficient;
    logic [PIX_W-1:0]         pred_pixel;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } out_item_t;

  typedef struct packed {
    logic       cap;
    logic [1:0] cap_idx;
    logic       calc;
    logic [1:0] sel;
  } bfly_ctl_t;

endpackage

// File: rtl/itr_ram.sv
// Generic single-write, single-read RAM with registered read data
module itr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/itr_bfly.sv
// Four-point 13/7/17 butterfly with operand gather registers and result select
module itr_bfly (
  input  logic                             clk,
  input  itr_pkg::bfly_ctl_t               ctl,
  input  logic signed [itr_pkg::ROW_W-1:0] din,
  input  logic [itr_pkg::PIX_W-1:0]        pin,
  output logic signed [itr_pkg::BF_W-1:0]  res,
  output logic [itr_pkg::PIX_W-1:0]        pres
);
  import itr_pkg::*;

  logic signed [ROW_W-1:0] opd_r [4];
  logic [PIX_W-1:0]        prd_r [4];
  logic signed [BF_W-1:0]  e0_r, e1_r, o0_r, o1_r;
  logic signed [BF_W-1:0]  a, b, c, d;

  // gather operands as read beats return
  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      opd_r[ctl.cap_idx] <= din;
      prd_r[ctl.cap_idx] <= pin;
    end
  end

  assign a = BF_W'(opd_r[0]);
  assign b = BF_W'(opd_r[1]);
  assign c = BF_W'(opd_r[2]);
  assign d = BF_W'(opd_r[3]);

  // register even and odd halves
  always_ff @(posedge clk) begin
    if (ctl.calc) begin
      e0_r <= (a + c) * K13;
      e1_r <= (a - c) * K13;
      o0_r <= b * K7 - d * K17;
      o1_r <= b * K17 + d * K7;
    end
  end

  // pick one output of the butterfly per write beat
  always_comb begin
    case (ctl.sel)
      2'd0:    res = e0_r + o1_r;
      2'd1:    res = e1_r + o0_r;
      2'd2:    res = e1_r - o0_r;
      2'd3:    res = e0_r - o1_r;
      default: res = e0_r + o1_r;
    endcase
  end

  assign pres = prd_r[ctl.sel];

endmodule

// File: rtl/itr_clip.sv
// Prediction add, rounding, scale-down and clip to the pixel range
module itr_clip (
  input  logic signed [itr_pkg::BF_W-1:0] col,
  input  logic [itr_pkg::PIX_W-1:0]       pred,
  output logic [itr_pkg::PIX_W-1:0]       pixel
);
  import itr_pkg::*;

  localparam logic [SUM_W-1:0] RND = SUM_W'(1) << (SCALE_SHIFT - 1);

  logic [SUM_W-1:0] sum;
  logic [SH_W-1:0]  shifted;

  assign sum     = SUM_W'(col) + (SUM_W'(pred) << SCALE_SHIFT) + RND;
  assign shifted = sum[SUM_W-1:SCALE_SHIFT];

  // clamp negative sums to zero and large ones to full scale
  always_comb begin
    if (sum[SUM_W-1]) begin
      pixel = '0;
    end else if (shifted > SH_W'(PIX_MAX)) begin
      pixel = PIX_W'(PIX_MAX);
    end else begin
      pixel = shifted[PIX_W-1:0];
    end
  end

endmodule

// File: rtl/inverse_4x4_transform_recon_top.sv
// Top level of the 4x4 inverse integer transform and pixel reconstruction block
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | start / busy         | in_data  (coefficient s24, pred_pixel u8)
//  result   | out_valid (strobe)   | out_data (pixel u8, last)
//
//  A block is 16 input beats, one per cycle while busy is low, row-major order.
//  After the 16th beat busy stays high through a row pass and a column pass, each
//  of 4 groups (4 RAM reads, a read-latency wait, 1 butterfly, 4 writes) serialised
//  by the single read port of each RAM; it then stays high while 16 pixels stream out.
//  Reset (rst_n low, synchronous) returns to loading position 0; RAMs are not cleared.
//  Results are single-cycle strobes; the receiver cannot stall them.
module inverse_4x4_transform_recon_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  itr_pkg::in_item_t  in_data,
  output logic               out_valid,
  output itr_pkg::out_item_t out_data
);
  import itr_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CALC  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic              pass_r, pass_nxt;
  logic [1:0]        grp_r, grp_nxt;
  logic [4:0]        cnt_r, cnt_nxt;
  logic [ADDR_W-1:0] load_cnt_r, load_cnt_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [1:0]        rd_idx_r, rd_idx_nxt;
  logic              out_vld_r, out_vld_nxt;
  logic              out_last_r, out_last_nxt;

  logic              rd_issue, out_issue;
  logic              coef_we, pred_we, row_we;
  logic [ADDR_W-1:0] pred_waddr, pred_raddr, row_waddr;
  logic [ADDR_W-1:0] coef_waddr, coef_raddr;
  logic [PIX_W-1:0]  pred_wdata, pred_rdata, clip_pix, bf_pred;
  logic [ROW_W-1:0]  coef_wdata, coef_rdata;
  logic signed [ROW_W-1:0] bf_din;
  logic signed [BF_W-1:0]  bf_res;
  logic              blk_done;
  bfly_ctl_t         bctl;

  // storage: coefficients overwritten in place by row-pass values,
  // prediction pixels overwritten in place by result pixels
  itr_ram #(.WIDTH(ROW_W), .DEPTH(BLK_N)) u_coef_ram (
    .clk   (clk),
    .we    (coef_we | row_we),
    .waddr (coef_waddr),
    .wdata (coef_wdata),
    .raddr (coef_raddr),
    .rdata (coef_rdata)
  );

  itr_ram #(.WIDTH(PIX_W), .DEPTH(BLK_N)) u_pred_ram (
    .clk   (clk),
    .we    (pred_we),
    .waddr (pred_waddr),
    .wdata (pred_wdata),
    .raddr (pred_raddr),
    .rdata (pred_rdata)
  );

  // butterfly operand select and control
  assign bf_din = $signed(coef_rdata);

  always_comb begin
    bctl.cap     = rd_vld_r;
    bctl.cap_idx = rd_idx_r;
    bctl.calc    = (state_r == S_CALC);
    bctl.sel     = cnt_r[1:0];
  end

  itr_bfly u_bfly (
    .clk  (clk),
    .ctl  (bctl),
    .din  (bf_din),
    .pin  (pred_rdata),
    .res  (bf_res),
    .pres (bf_pred)
  );

  itr_clip u_clip (
    .col   (bf_res),
    .pred  (bf_pred),
    .pixel (clip_pix)
  );

  // address and data steering
  assign pred_raddr = (state_r == S_OUT) ? cnt_r[ADDR_W-1:0] : {cnt_r[1:0], grp_r};
  assign pred_waddr = (state_r == S_LOAD) ? load_cnt_r : {cnt_r[1:0], grp_r};
  assign pred_wdata = (state_r == S_LOAD) ? in_data.pred_pixel : clip_pix;
  assign row_waddr  = {grp_r, cnt_r[1:0]};
  assign coef_waddr = (state_r == S_LOAD) ? load_cnt_r : row_waddr;
  assign coef_wdata = (state_r == S_LOAD) ? ROW_W'($signed(in_data.coefficient))
                                          : bf_res[ROW_W-1:0];
  assign coef_raddr = (pass_r == PASS_COL) ? {cnt_r[1:0], grp_r} : {grp_r, cnt_r[1:0]};

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    pass_nxt     = pass_r;
    grp_nxt      = grp_r;
    cnt_nxt      = cnt_r;
    load_cnt_nxt = load_cnt_r;
    rd_issue     = 1'b0;
    out_issue    = 1'b0;
    coef_we      = 1'b0;
    pred_we      = 1'b0;
    row_we       = 1'b0;
    case (state_r)
      S_LOAD: begin
        if (start) begin
          coef_we      = 1'b1;
          pred_we      = 1'b1;
          load_cnt_nxt = load_cnt_r + 1'b1;
          if (load_cnt_r == ADDR_W'(BLK_N - 1)) begin
            state_nxt = S_READ;
            pass_nxt  = PASS_ROW;
            grp_nxt   = '0;
            cnt_nxt   = '0;
          end
        end
      end
      S_READ: begin
        if (!cnt_r[2]) begin
          rd_issue = 1'b1;
          cnt_nxt  = cnt_r + 1'b1;
        end else begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        state_nxt = S_WRITE;
        cnt_nxt   = '0;
      end
      S_WRITE: begin
        if (pass_r == PASS_ROW) begin
          row_we = 1'b1;
        end else begin
          pred_we = 1'b1;
        end
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r[1:0] == 2'd3) begin
          cnt_nxt = '0;
          grp_nxt = grp_r + 1'b1;
          if (grp_r == 2'd3) begin
            if (pass_r == PASS_ROW) begin
              pass_nxt  = PASS_COL;
              state_nxt = S_READ;
            end else begin
              state_nxt = S_OUT;
            end
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_OUT: begin
        if (!cnt_r[4]) begin
          out_issue = 1'b1;
          cnt_nxt   = cnt_r + 1'b1;
        end else begin
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  assign rd_vld_nxt   = rd_issue;
  assign rd_idx_nxt   = cnt_r[1:0];
  assign out_vld_nxt  = out_issue;
  assign out_last_nxt = out_issue && (cnt_r[ADDR_W-1:0] == ADDR_W'(BLK_N - 1));

  // advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      pass_r     <= PASS_ROW;
      grp_r      <= '0;
      cnt_r      <= '0;
      load_cnt_r <= '0;
      rd_vld_r   <= 1'b0;
      rd_idx_r   <= '0;
      out_vld_r  <= 1'b0;
      out_last_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      pass_r     <= pass_nxt;
      grp_r      <= grp_nxt;
      cnt_r      <= cnt_nxt;
      load_cnt_r <= load_cnt_nxt;
      rd_vld_r   <= rd_vld_nxt;
      rd_idx_r   <= rd_idx_nxt;
      out_vld_r  <= out_vld_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  // ports
  assign busy           = (state_r != S_LOAD);
  assign out_valid      = out_vld_r;
  assign out_data.pixel = pred_rdata;
  assign out_data.last  = out_last_r;

  // sixteenth beat of a block accepted
  assign blk_done = start && !busy && (load_cnt_r == ADDR_W'(BLK_N - 1));

`include "inverse_4x4_transform_recon_top_defines.svh"

  `ITR_ASSERT_NOW(a_out_while_busy, out_vld_r, busy, "result beat outside the output phase")
  `ITR_ASSERT_NOW(a_last_has_valid, out_last_r, out_vld_r, "last marker without a result beat")
  `ITR_ASSERT_NEXT(a_last_ends_block, out_last_r, !out_vld_r && !busy, "block did not end")
  `ITR_ASSERT_NEXT(a_full_block_busy, blk_done, busy && (load_cnt_r == '0), "no transform")

endmodule

// File: bench/inverse_4x4_transform_recon_top_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for the 4x4 inverse transform and pixel reconstruction block
module inverse_4x4_transform_recon_top_tb;
  import itr_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 120;
  localparam int RANDOM_BLOCKS = 9;

  typedef longint quad_t [4];

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t in_data = '0;
  logic out_valid;
  out_item_t out_data;

  in_item_t pending_beats_q [$];
  out_item_t recon_pixels_q [$];

  // Shadow of the block's buffers
  longint coef_buf [BLK_N];
  logic [PIX_W-1:0] pred_buf [BLK_N];
  int load_pos;

  int mismatch_count;
  int idle_cycles;
  int drv_wait;
  bit drv_burst;
  logic start_nx;
  out_item_t want;

  inverse_4x4_transform_recon_top dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // One 4-point 13/7/17 butterfly
  function automatic quad_t butterfly4(input longint a, input longint b,
                                       input longint c, input longint d);
    quad_t r;
    longint e0, e1, o0, o1;
    e0 = (a + c) * 13;
    e1 = (a - c) * 13;
    o0 = b * 7 - d * 17;
    o1 = b * 17 + d * 7;
    r[0] = e0 + o1;
    r[1] = e1 + o0;
    r[2] = e1 - o0;
    r[3] = e0 - o1;
    return r;
  endfunction

  // Transform the loaded block, add prediction, round, clip; queue 16 pixels
  task automatic reconstruct_block();
    longint rows [BLK_N];
    longint cols [BLK_N];
    quad_t r;
    longint sum, shifted;
    out_item_t px;
    for (int y = 0; y < 4; y++) begin
      r = butterfly4(coef_buf[4*y], coef_buf[4*y+1], coef_buf[4*y+2], coef_buf[4*y+3]);
      for (int x = 0; x < 4; x++) rows[4*y+x] = r[x];
    end
    for (int x = 0; x < 4; x++) begin
      r = butterfly4(rows[x], rows[x+4], rows[x+8], rows[x+12]);
      for (int y = 0; y < 4; y++) cols[4*y+x] = r[y];
    end
    for (int p = 0; p < BLK_N; p++) begin
      sum = cols[p] + (longint'(pred_buf[p]) <<< SCALE_SHIFT)
            + (longint'(1) <<< (SCALE_SHIFT - 1));
      if (sum < 0) begin
        px.pixel = '0;
      end else begin
        shifted = sum >>> SCALE_SHIFT;
        px.pixel = (shifted > PIX_MAX) ? PIX_W'(PIX_MAX) : PIX_W'(shifted);
      end
      px.last = (p == BLK_N - 1);
      recon_pixels_q.push_back(px);
    end
  endtask

  // Drive input beats from the pending queue with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      drv_wait = $urandom_range(0, 15);
    end else begin
      start_nx = start;
      if (start && !busy) begin
        void'(pending_beats_q.pop_front());
        start_nx = 1'b0;
        if ($urandom_range(0, 19) == 0) drv_burst = !drv_burst;
        drv_wait = drv_burst ? 0 : $urandom_range(0, 15);
      end
      if (!start_nx) begin
        if (drv_wait > 0) begin
          drv_wait--;
        end else if (pending_beats_q.size() != 0) begin
          in_data <= pending_beats_q[0];
          start_nx = 1'b1;
        end
      end
      start <= start_nx;
    end
  end

  // Track accepted beats and check every result strobe
  always @(posedge clk) begin
    if (!rst_n) begin
      load_pos = 0;
    end else begin
      if (start && !busy) begin
        coef_buf[load_pos] = longint'($signed(in_data.coefficient));
        pred_buf[load_pos] = in_data.pred_pixel;
        if (load_pos == BLK_N - 1) begin
          load_pos = 0;
          reconstruct_block();
        end else begin
          load_pos++;
        end
      end
      if (out_valid) begin
        if (recon_pixels_q.size() == 0) begin
          report_mismatch($sformatf("unexpected pixel %0d last %0b",
                                    out_data.pixel, out_data.last));
        end else begin
          want = recon_pixels_q.pop_front();
          if (out_data.pixel !== want.pixel)
            report_mismatch($sformatf("pixel got %0d want %0d", out_data.pixel, want.pixel));
          if (out_data.last !== want.last)
            report_mismatch($sformatf("last got %0b want %0b", out_data.last, want.last));
        end
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("inverse_4x4_transform_recon_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int dir_coef [BLK_N];
    int dir_pred [BLK_N];
    in_item_t beat;
    int style, w, mag;

    // Extremes: saturating coefficients in both directions, pixel rails
    dir_coef = '{8388607, -8388608, 8388607, -8388608, 0, 1, -1, 0,
                 -8388608, 0, 8388607, 0, 4096, -4096, 65536, -65536};
    dir_pred = '{255, 0, 255, 0, 128, 0, 255, 1, 254, 255, 0, 127, 128, 255, 0, 255};
    for (int p = 0; p < BLK_N; p++) begin
      beat.coefficient = COEF_W'(dir_coef[p]);
      beat.pred_pixel = PIX_W'(dir_pred[p]);
      pending_beats_q.push_back(beat);
    end

    // Random blocks in several styles: realistic, sparse, full range, mixed
    for (int b = 0; b < RANDOM_BLOCKS; b++) begin
      style = $urandom_range(0, 3);
      for (int p = 0; p < BLK_N; p++) begin
        case (style)
          0: w = $urandom_range(4, 20);
          1: w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 18) : 0;
          2: w = 24;
          default: w = $urandom_range(0, 24);
        endcase
        if (w >= 24) begin
          beat.coefficient = COEF_W'($urandom());
        end else if (w == 0) begin
          beat.coefficient = '0;
        end else begin
          mag = $urandom_range(0, (1 << w) - 1);
          beat.coefficient = COEF_W'($urandom_range(0, 1) ? -mag : mag);
        end
        case ($urandom_range(0, 7))
          0: beat.pred_pixel = '0;
          1: beat.pred_pixel = PIX_W'(PIX_MAX);
          default: beat.pred_pixel = PIX_W'($urandom_range(0, PIX_MAX));
        endcase
        pending_beats_q.push_back(beat);
      end
    end

    // Hold reset, then release
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all beats taken, all pixels back, then settle
    while (pending_beats_q.size() != 0 || start) @(posedge clk);
    while (recon_pixels_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (recon_pixels_q.size() != 0)
      report_mismatch($sformatf("%0d pixels never arrived", recon_pixels_q.size()));

    if (mismatch_count == 0) begin
      $display("inverse_4x4_transform_recon_top verification clean");
    end else begin
      $display("inverse_4x4_transform_recon_top verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/itr_pkg.sv
rtl/itr_ram.sv
rtl/itr_bfly.sv
rtl/itr_clip.sv
rtl/inverse_4x4_transform_recon_top.sv
bench/inverse_4x4_transform_recon_top_tb.sv
